FILE: rtl/adcss_pkg.sv
// shared types, constants and scaling function for the adc sample scale and stats unit
package adcss_pkg;

  localparam int SampleW   = 23;
  localparam int SumW      = 32;
  localparam int AvgW      = 31;
  localparam int NumPtsW   = 17;
  localparam int DivisorW  = NumPtsW + 1;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = NumPtsW;
  localparam int QueueDepth = 2;
  localparam int MaxPoints = 65536;

  localparam logic [7:0]         ZeroReset   = 8'd128;
  localparam logic [1:0]         RangeReset  = 2'd3;
  localparam logic [NumPtsW-1:0] NumPtsReset = 17'd1024;

  localparam logic signed [SampleW-1:0] SamplePos = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleNeg = {1'b1, {(SampleW-1){1'b0}}};

  // quant step per range code
  localparam logic [13:0] QuantTable [4] = '{14'd2000, 14'd4000, 14'd8000, 14'd16000};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_LINE0  = 3'd0,
    CFG_ZERO_LINE1  = 3'd1,
    CFG_RANGE_LINE0 = 3'd2,
    CFG_RANGE_LINE1 = 3'd3,
    CFG_STATS_EN    = 3'd4,
    CFG_NUM_POINTS  = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_SECOND,
    ST_DIV
  } back_state_e;

  typedef struct packed {
    logic [7:0]         zero_line0;
    logic [7:0]         zero_line1;
    logic [1:0]         range_line0;
    logic [1:0]         range_line1;
    logic               stats_enable;
    logic [NumPtsW-1:0] num_points;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] s0;
    logic signed [SampleW-1:0] s1;
    logic                      last;
  } entry_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      pair_end;
    logic                      stats_valid;
    logic signed [SampleW-1:0] min_value;
    logic signed [SampleW-1:0] max_value;
    logic signed [AvgW-1:0]    average;
    logic signed [SumW-1:0]    integral;
  } result_t;

  // (b + zero - 256) * quant
  function automatic logic signed [SampleW-1:0] scale_byte(
    input logic [7:0] b,
    input logic [7:0] zero,
    input logic [1:0] range
  );
    logic signed [9:0]  off;
    logic signed [14:0] quant;
    logic signed [24:0] prod;
    off   = $signed({2'b00, b}) + $signed({2'b00, zero}) - 10'sd256;
    quant = $signed({1'b0, QuantTable[range]});
    prod  = off * quant;
    return prod[SampleW-1:0];
  endfunction

endpackage

FILE: rtl/adc_sample_scale_and_stats_unit.sv
// top level: config registers, front stage, entry queue and back stage
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: data_word; tuser: line; tlast: last_word
// m_axis    out  m_axis_tvalid/tready       tdata: sample, min, max, average, integral;
//                                           tuser: stats_valid; tlast: pair_end
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// each word gives two results, its first sample and then its second.
// a last word with statistics enabled also waits on the 32-step divider before its second result.
// the front scales a word into its register and parks it in a two-entry queue, so input
// words keep flowing while the back waits on the output or the divider.
// reset clears all control state and loads the config defaults; no clearing pass.
module adc_sample_scale_and_stats_unit #(
  parameter int MaxPoints = adcss_pkg::MaxPoints
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [15:0] data_word
  input  logic                            s_axis_tuser,  // [0] line
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [22:0] sample, [45:23] min_value, [68:46] max_value, [99:69] average,
  // [131:100] integral, [135:132] zero
  output logic [135:0]                    m_axis_tdata,
  output logic                            m_axis_tuser,  // [0] stats_valid
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [adcss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [adcss_pkg::CfgDataW-1:0]  cfg_data_i
);

  adcss_pkg::cfg_t    cfg_q;
  adcss_pkg::entry_t  f_entry, q_entry;
  adcss_pkg::result_t res;
  logic               q_full, q_push, q_pop, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_line0   <= adcss_pkg::ZeroReset;
      cfg_q.zero_line1   <= adcss_pkg::ZeroReset;
      cfg_q.range_line0  <= adcss_pkg::RangeReset;
      cfg_q.range_line1  <= adcss_pkg::RangeReset;
      cfg_q.stats_enable <= 1'b0;
      cfg_q.num_points   <= adcss_pkg::NumPtsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        adcss_pkg::CFG_ZERO_LINE0:  cfg_q.zero_line0   <= cfg_data_i[7:0];
        adcss_pkg::CFG_ZERO_LINE1:  cfg_q.zero_line1   <= cfg_data_i[7:0];
        adcss_pkg::CFG_RANGE_LINE0: cfg_q.range_line0  <= cfg_data_i[1:0];
        adcss_pkg::CFG_RANGE_LINE1: cfg_q.range_line1  <= cfg_data_i[1:0];
        adcss_pkg::CFG_STATS_EN:    cfg_q.stats_enable <= cfg_data_i[0];
        adcss_pkg::CFG_NUM_POINTS:  cfg_q.num_points   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  adcss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_word_i (s_axis_tdata),
    .line_i      (s_axis_tuser),
    .last_word_i (s_axis_tlast),
    .cfg_i       (cfg_q),
    .full_i      (q_full),
    .push_o      (q_push),
    .entry_o     (f_entry)
  );

  adcss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  adcss_back #(
    .MaxPoints (MaxPoints)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {4'b0000, res.integral, res.average, res.max_value,
                         res.min_value, res.sample};
  assign m_axis_tuser = res.stats_valid;
  assign m_axis_tlast = res.pair_end;

endmodule

FILE: rtl/adcss_front.sv
// front stage: accepts words and scales both samples into a queue entry
module adcss_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          data_word_i,
  input  logic                 line_i,
  input  logic                 last_word_i,
  input  adcss_pkg::cfg_t      cfg_i,
  input  logic                 full_i,
  output logic                 push_o,
  output adcss_pkg::entry_t    entry_o
);

  logic              valid_q;
  adcss_pkg::entry_t entry_q, entry_d;
  logic [7:0]        zero;
  logic [1:0]        range;
  logic              accept;

  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = valid_q && !full_i;
  assign entry_o    = entry_q;

  always_comb begin
    zero          = line_i ? cfg_i.zero_line1 : cfg_i.zero_line0;
    range         = line_i ? cfg_i.range_line1 : cfg_i.range_line0;
    entry_d.s0    = adcss_pkg::scale_byte(data_word_i[7:0], zero, range);
    entry_d.s1    = adcss_pkg::scale_byte(data_word_i[15:8], zero, range);
    entry_d.last  = last_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

FILE: rtl/adcss_queue.sv
// short queue of scaled word entries between front and back
module adcss_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  adcss_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output adcss_pkg::entry_t entry_o
);

  localparam int Depth = adcss_pkg::QueueDepth;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  adcss_pkg::entry_t mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/adcss_div.sv
// restoring divider, one quotient bit per cycle, signed dividend truncated toward zero
module adcss_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [adcss_pkg::SumW-1:0]      dividend_i,
  input  logic [adcss_pkg::DivisorW-1:0]         divisor_i,
  output logic                                   busy_o,
  output logic signed [adcss_pkg::AvgW-1:0]      quotient_o
);

  localparam int SumW = adcss_pkg::SumW;
  localparam int DivW = adcss_pkg::DivisorW;
  localparam int CntW = $clog2(SumW);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  logic [SumW-1:0]   mag_q;
  logic [DivW-1:0]   rem_q;
  logic [DivW-1:0]   div_q;
  logic [DivW:0]     rem_sh;
  logic [DivW:0]     rem_sub;
  logic              q_bit;
  logic [SumW-1:0]   signed_q;

  always_comb begin
    rem_sh   = {rem_q, mag_q[SumW-1]};
    rem_sub  = rem_sh - {1'b0, div_q};
    q_bit    = (rem_sh >= {1'b0, div_q});
    signed_q = neg_q ? (~mag_q + 1'b1) : mag_q;
  end

  assign busy_o     = busy_q;
  assign quotient_o = signed_q[adcss_pkg::AvgW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(SumW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SumW-1];
      mag_q <= dividend_i[SumW-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[SumW-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
    end
  end

endmodule

FILE: rtl/adcss_back.sv
// back stage: run statistics, result sequencing and output register
module adcss_back #(
  parameter int MaxPoints = adcss_pkg::MaxPoints
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  adcss_pkg::cfg_t    cfg_i,
  input  logic               q_valid_i,
  input  adcss_pkg::entry_t  q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output adcss_pkg::result_t out_o
);

  localparam int SampleW = adcss_pkg::SampleW;
  localparam int SumW    = adcss_pkg::SumW;
  localparam int DivW    = adcss_pkg::DivisorW;

  adcss_pkg::back_state_e state_q, state_d;
  adcss_pkg::result_t     res_q, res_d;
  logic                   out_valid_q, out_load;
  logic                   out_free;

  logic signed [SampleW-1:0] min_q, max_q, min_d, max_d;
  logic signed [SampleW-1:0] base_min, base_max, lo, hi;
  logic signed [SumW-1:0]    sum_q, sum_d, base_sum;
  logic                      open_q, open_d, acc_load;

  logic                      div_start, div_busy;
  logic signed [adcss_pkg::AvgW-1:0] div_quot;
  logic [DivW-1:0]           divisor;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

  // divisor: num_points rounded up to even, held in 2..MaxPoints
  always_comb begin
    logic [DivW-1:0] rnd;
    rnd = {1'b0, cfg_i.num_points} + 1'b1;
    rnd = {rnd[DivW-1:1], 1'b0};
    if (rnd < DivW'(2)) begin
      rnd = DivW'(2);
    end
    if (32'(rnd) > 32'(MaxPoints)) begin
      rnd = DivW'(MaxPoints);
    end
    divisor = rnd;
  end

  // statistics fold for both samples of the head entry
  always_comb begin
    base_min = open_q ? min_q : adcss_pkg::SamplePos;
    base_max = open_q ? max_q : adcss_pkg::SampleNeg;
    base_sum = open_q ? sum_q : '0;
    lo       = (q_entry_i.s0 < q_entry_i.s1) ? q_entry_i.s0 : q_entry_i.s1;
    hi       = (q_entry_i.s0 > q_entry_i.s1) ? q_entry_i.s0 : q_entry_i.s1;
    min_d    = (lo < base_min) ? lo : base_min;
    max_d    = (hi > base_max) ? hi : base_max;
    sum_d    = base_sum + {{(SumW-SampleW){q_entry_i.s0[SampleW-1]}}, q_entry_i.s0}
                        + {{(SumW-SampleW){q_entry_i.s1[SampleW-1]}}, q_entry_i.s1};
  end

  always_comb begin
    state_d   = state_q;
    res_d     = '0;
    out_load  = 1'b0;
    acc_load  = 1'b0;
    open_d    = open_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      adcss_pkg::ST_FIRST: begin
        if (q_valid_i && out_free) begin
          res_d.sample = q_entry_i.s0;
          out_load     = 1'b1;
          acc_load     = 1'b1;
          open_d       = 1'b1;
          state_d      = adcss_pkg::ST_SECOND;
        end
      end
      adcss_pkg::ST_SECOND: begin
        if (q_entry_i.last && cfg_i.stats_enable) begin
          div_start = 1'b1;
          state_d   = adcss_pkg::ST_DIV;
        end else if (out_free) begin
          res_d.sample      = q_entry_i.s1;
          res_d.pair_end    = 1'b1;
          res_d.stats_valid = q_entry_i.last;
          out_load          = 1'b1;
          q_pop_o           = 1'b1;
          if (q_entry_i.last) begin
            open_d = 1'b0;
          end
          state_d = adcss_pkg::ST_FIRST;
        end
      end
      adcss_pkg::ST_DIV: begin
        if (!div_busy && out_free) begin
          res_d.sample      = q_entry_i.s1;
          res_d.pair_end    = 1'b1;
          res_d.stats_valid = 1'b1;
          res_d.min_value   = min_q;
          res_d.max_value   = max_q;
          res_d.average     = div_quot;
          res_d.integral    = sum_q;
          out_load          = 1'b1;
          q_pop_o           = 1'b1;
          open_d            = 1'b0;
          state_d           = adcss_pkg::ST_FIRST;
        end
      end
      default: state_d = adcss_pkg::ST_FIRST;
    endcase
  end

  adcss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adcss_pkg::ST_FIRST;
      out_valid_q <= 1'b0;
      open_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
    if (acc_load) begin
      min_q <= min_d;
      max_q <= max_d;
      sum_q <= sum_d;
    end
  end

  a_stats_on_pair_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.stats_valid |-> res_q.pair_end)
    else $error("stats shown on a first result");

  a_div_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == adcss_pkg::ST_DIV |-> q_valid_i && q_entry_i.last)
    else $error("division running without a last entry at the head");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_stats_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.stats_valid |-> res_q.integral == '0 && res_q.min_value == '0)
    else $error("statistics fields not cleared outside a run end");

  a_pop_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q != adcss_pkg::ST_FIRST)
    else $error("entry popped before its first sample went out");

endmodule

FILE: tb/adcss_result_checker.sv
// checker for the adc sample scale and stats unit: predicts both results of each word and compares
module adcss_result_checker
  import adcss_pkg::*;
#(
  parameter int MaxPoints = adcss_pkg::MaxPoints
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [15:0] data_word
  input  logic                  s_axis_tuser,  // [0] line
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [22:0] sample, [45:23] min_value, [68:46] max_value, [99:69] average,
  // [131:100] integral, [135:132] zero
  input  logic [135:0]          m_axis_tdata,
  input  logic                  m_axis_tuser,  // [0] stats_valid
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  localparam int StepTable [4] = '{2000, 4000, 8000, 16000};

  // register copies, indexed by line
  logic [7:0]         zero_code [2] = '{ZeroReset, ZeroReset};
  logic [1:0]         step_code [2] = '{RangeReset, RangeReset};
  logic               stats_on      = 1'b0;
  logic [NumPtsW-1:0] point_count   = NumPtsReset;

  // running statistics of the open run
  logic signed [SampleW-1:0] run_lo     = SamplePos;
  logic signed [SampleW-1:0] run_hi     = SampleNeg;
  logic [SumW-1:0]           run_total  = '0;
  logic                      run_active = 1'b0;

  result_t results_due [$];
  int      mismatches = 0;

  function automatic string show(input result_t r);
    return $sformatf("sample %0d pair_end %0b stats_valid %0b min %0d max %0d avg %0d integral %0d",
                     r.sample, r.pair_end, r.stats_valid, r.min_value, r.max_value,
                     r.average, r.integral);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t                   want;
    result_t                   got;
    logic [7:0]                zero;
    logic [1:0]                step_sel;
    logic signed [SampleW-1:0] pair [2];
    longint                    divisor;
    int                        offset;
    if (!rst_ni) begin
      zero_code   = '{ZeroReset, ZeroReset};
      step_code   = '{RangeReset, RangeReset};
      stats_on    = 1'b0;
      point_count = NumPtsReset;
      run_lo      = SamplePos;
      run_hi      = SampleNeg;
      run_total   = '0;
      run_active  = 1'b0;
      mismatches  = 0;
      results_due.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ZERO_LINE0:  zero_code[0] = cfg_data_i[7:0];
          CFG_ZERO_LINE1:  zero_code[1] = cfg_data_i[7:0];
          CFG_RANGE_LINE0: step_code[0] = cfg_data_i[1:0];
          CFG_RANGE_LINE1: step_code[1] = cfg_data_i[1:0];
          CFG_STATS_EN:    stats_on     = cfg_data_i[0];
          CFG_NUM_POINTS:  point_count  = cfg_data_i[NumPtsW-1:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.sample      = m_axis_tdata[22:0];
        got.min_value   = m_axis_tdata[45:23];
        got.max_value   = m_axis_tdata[68:46];
        got.average     = m_axis_tdata[99:69];
        got.integral    = m_axis_tdata[131:100];
        got.pair_end    = m_axis_tlast;
        got.stats_valid = m_axis_tuser;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch, expected: %s", show(want));
              $display("                 actual:   %s", show(got));
            end
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        zero     = zero_code[s_axis_tuser];
        step_sel = step_code[s_axis_tuser];
        if (!run_active) begin
          run_lo     = SamplePos;
          run_hi     = SampleNeg;
          run_total  = '0;
          run_active = 1'b1;
        end
        for (int k = 0; k < 2; k++) begin
          offset  = int'(s_axis_tdata[8*k +: 8]) + int'(zero) - 256;
          pair[k] = SampleW'(offset * StepTable[step_sel]);
          if (pair[k] < run_lo) run_lo = pair[k];
          if (pair[k] > run_hi) run_hi = pair[k];
          run_total = run_total + {{(SumW-SampleW){pair[k][SampleW-1]}}, pair[k]};
        end
        want = '0;
        want.sample = pair[0];
        results_due.push_back(want);
        want.sample   = pair[1];
        want.pair_end = 1'b1;
        if (s_axis_tlast) begin
          want.stats_valid = 1'b1;
          if (stats_on) begin
            // divisor rounds up to even, then clamps to 2..MaxPoints
            divisor = (longint'(point_count) + 1) / 2 * 2;
            if (divisor < 2) divisor = 2;
            if (divisor > MaxPoints) divisor = MaxPoints;
            want.min_value = run_lo;
            want.max_value = run_hi;
            want.average   = AvgW'(longint'($signed(run_total)) / divisor);
            want.integral  = run_total;
          end
          run_active = 1'b0;
        end
        results_due.push_back(want);
      end

      pending_o        <= results_due.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/tb_adc_sample_scale_and_stats_unit.sv
// testbench top for the adc sample scale and stats unit: stimulus, output stalls and verdict
module tb_adc_sample_scale_and_stats_unit;
  import adcss_pkg::*;

  localparam int ItemsTotal   = 1250;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 48;
  localparam int StallLimit   = 3000;
  localparam int WrapRunWords = 280;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // [15:0] data_word
  logic                s_axis_tuser  = 1'b0;  // [0] line
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [135:0]        m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int words_sent    = 0;
  int runs_sent     = 0;
  int reg_writes    = 0;
  int mismatch_count;
  int results_pending;

  adc_sample_scale_and_stats_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  adcss_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // output side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen     <= hold_requests;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", StallLimit);
    $display("adc_sample_scale_and_stats_unit verification failed");
    $finish;
  end

  // valid stays high into the next item unless a gap is drawn
  task automatic send_word(input logic [15:0] word, input logic line, input logic last_word);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= line;
    s_axis_tlast  <= last_word;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (last_word) runs_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  // unused bits of the narrow registers carry junk, they must be dropped
  task automatic set_config(input logic [7:0] zero0, input logic [7:0] zero1,
                            input logic [1:0] step0, input logic [1:0] step1,
                            input logic stats, input logic [NumPtsW-1:0] points);
    cfg_write(CFG_ZERO_LINE0, {9'($urandom), zero0});
    cfg_write(CFG_ZERO_LINE1, {9'($urandom), zero1});
    cfg_write(CFG_RANGE_LINE0, {15'($urandom), step0});
    cfg_write(CFG_RANGE_LINE1, {15'($urandom), step1});
    cfg_write(CFG_STATS_EN, {16'($urandom), stats});
    cfg_write(CFG_NUM_POINTS, points);
    // writes to unused indexes change nothing
    for (int k = int'(CFG_NUM_POINTS) + 1; k < (1 << CfgIdxW); k++) begin
      cfg_write(CfgIdxW'(k), CfgDataW'($urandom));
    end
  endtask

  task automatic random_config();
    logic [7:0]         zeros [2];
    logic [NumPtsW-1:0] points;
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(3))
        0:       zeros[k] = 8'h00;
        1:       zeros[k] = 8'hFF;
        default: zeros[k] = 8'($urandom);
      endcase
    end
    case ($urandom_range(9))
      0:       points = '0;
      1:       points = NumPtsW'(1);
      2:       points = NumPtsW'(2);
      3:       points = NumPtsW'(3);
      4:       points = NumPtsW'(MaxPoints - 1);
      5:       points = NumPtsW'(MaxPoints);
      6:       points = '1;
      7:       points = NumPtsW'($urandom);
      default: points = NumPtsW'($urandom_range(64, 2));
    endcase
    set_config(zeros[0], zeros[1], 2'($urandom), 2'($urandom), $urandom_range(3) != 0, points);
  endtask

  // biased runs keep both bytes near one end of the code range
  task automatic send_run(input int len, input logic line, input logic mixed,
                          input logic biased, input logic high_side);
    logic [15:0] word;
    for (int i = 0; i < len; i++) begin
      if (!biased) word = 16'($urandom);
      else if (high_side) word = {6'h3F, 2'($urandom), 6'h3F, 2'($urandom)};
      else word = {6'h00, 2'($urandom), 6'h00, 2'($urandom)};
      send_word(word, mixed ? 1'($urandom) : line, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int phase_end;
    int run_idx;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct <= 80;

    // register values out of reset, statistics off
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h0080, 1'b1, 1'b1);
    wait_drained();

    // smallest quant on line 0, largest on line 1, both zero extremes
    set_config(8'h00, 8'hFF, 2'd0, 2'd3, 1'b1, NumPtsW'(2));
    send_word(16'h0000, 1'b0, 1'b1);
    send_word(16'hFFFF, 1'b1, 1'b1);
    // line changes inside one run
    send_word(16'h00FF, 1'b0, 1'b0);
    send_word(16'hFF00, 1'b1, 1'b1);
    wait_drained();

    set_config(8'hFF, 8'hFF, 2'd3, 2'd3, 1'b1, NumPtsW'(MaxPoints));
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h8001, 1'b0, 1'b1);
    wait_drained();

    // odd and out of range point counts
    cfg_write(CFG_NUM_POINTS, NumPtsW'(3));
    send_word(16'h1234, 1'b0, 1'b1);
    wait_drained();
    cfg_write(CFG_NUM_POINTS, '0);
    send_word(16'hABCD, 1'b1, 1'b1);
    wait_drained();
    cfg_write(CFG_NUM_POINTS, '1);
    send_word(16'h5AA5, 1'b1, 1'b1);
    wait_drained();
    cfg_write(CFG_NUM_POINTS, NumPtsW'(1));
    send_word(16'h7E81, 1'b0, 1'b1);
    wait_drained();

    // statistics off: run still closes with zeroed fields
    cfg_write(CFG_STATS_EN, '0);
    send_word(16'h7F80, 1'b0, 1'b0);
    send_word(16'h807F, 1'b1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct <= 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct <= 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_end = words_sent + (ItemsTotal - words_sent) / (3 - phase);

      if (phase == 2) begin
        // long run of near-full-scale samples so the integral wraps
        wait_drained();
        set_config(8'hFF, 8'h00, 2'd3, 2'd3, 1'b1, NumPtsW'(MaxPoints));
        send_run(WrapRunWords, 1'b0, 1'b0, 1'b1, 1'b1);
      end

      run_idx = 0;
      while (words_sent < phase_end) begin
        if (run_idx % 5 == 0) begin
          wait_drained();
          random_config();
        end
        case ($urandom_range(99)) inside
          [0:69]:  len = $urandom_range(8, 1);
          [70:94]: len = $urandom_range(40, 9);
          default: len = $urandom_range(120, 41);
        endcase
        // receiver holds off while the sender keeps offering a longer run
        if (run_idx == 3) begin
          hold_requests <= hold_requests + 1;
          len = 24;
        end
        send_run(len, 1'($urandom), $urandom_range(99) < 15, $urandom_range(99) < 20,
                 1'($urandom));
        run_idx++;
      end
    end

    wait_drained();
    $display("run covered %0d words in %0d runs with %0d register writes", words_sent, runs_sent,
             reg_writes);
    $display("three stall profiles, a %0d-cycle output hold-off and a wrapping integral",
             HoldCycles);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("adc_sample_scale_and_stats_unit verification clean");
    end else begin
      $display("adc_sample_scale_and_stats_unit verification failed");
    end
    $finish;
  end

endmodule
